FILE: src/masked_byte_pattern_search_assert.svh
// assertion helpers for the top-level rtl
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

// same-cycle implication
`define MBPS_CHECK_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MBPS_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

  localparam int MAX_PATTERN  = 256;
  localparam int MAX_HITS     = 1024;
  localparam int ADDR_BITS    = 48;
  localparam int BYTE_BITS    = 8;
  localparam int IDX_BITS     = $clog2(MAX_PATTERN);
  localparam int LEN_BITS     = 9;
  localparam int SUM_BITS     = LEN_BITS + 1;
  localparam int HIT_BITS     = 11;
  localparam int REQ_BITS     = 2;
  localparam int CFG_BITS     = 48;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [REQ_BITS-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_SCAN  = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_START = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIT_LIMIT      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_START    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_END      = 2'd3;

  // shared controls broadcast to every cell
  typedef struct packed {
    logic                 step;
    logic                 clr;
    logic [BYTE_BITS-1:0] cmp_byte;
    logic [BYTE_BITS-1:0] pat_data;
    logic [BYTE_BITS-1:0] msk_data;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/mbps_cell.sv
`default_nettype none

module mbps_cell import mbps_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic                 load_we,
  input  wire logic [BYTE_BITS-1:0] byte_in,
  input  wire logic                 prev_hit,
  output logic      [BYTE_BITS-1:0] byte_q,
  output logic                      hit
);

  logic [BYTE_BITS-1:0] pat;
  logic [BYTE_BITS-1:0] msk;
  logic                 pos_match;

  // a zero mask bit makes that bit a don't care
  assign pos_match = ((ctrl.cmp_byte ^ pat) & msk) == '0;

  always_ff @(posedge clk) begin
    if (load_we) begin
      pat <= ctrl.pat_data;
      msk <= ctrl.msk_data;
    end
    if (ctrl.step) begin
      byte_q <= byte_in;
    end
  end

  // hit: the newest bytes match pattern positions 0 up to this cell
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.step) begin
      hit <= !ctrl.clr && prev_hit && pos_match;
    end
  end

endmodule

`default_nettype wire

FILE: src/masked_byte_pattern_search.sv
// Masked byte pattern search. Pattern and mask bytes are loaded with load beats, then
// address-tagged data bytes are streamed in with scan beats; every window of contiguous,
// in-range bytes that matches the pattern, up to the hit limit, yields one result beat
// carrying the window's first address, the running hit count and a flag on the hit that
// reaches the limit. A row of 256 cells holds the pattern, the recent bytes and a running
// partial-match flag per position, so load, start and scan beats are taken back to back
// while results can be delivered; a byte's verdict is read from the cell row in the cycle
// after its shift. A pattern load while a run of bytes is open makes the next scan beat
// wait while the held bytes are replayed through the cell row against the new pattern.
`default_nettype none

module masked_byte_pattern_search import mbps_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [REQ_BITS-1:0]     req_type,
  input  wire logic [IDX_BITS-1:0]     entry_index,
  input  wire logic [BYTE_BITS-1:0]    pattern_value,
  input  wire logic [BYTE_BITS-1:0]    mask_value,
  input  wire logic [BYTE_BITS-1:0]    data_byte,
  input  wire logic [ADDR_BITS-1:0]    byte_address,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [ADDR_BITS-1:0]    match_address,
  output logic      [HIT_BITS-1:0]     hits_so_far,
  output logic                         limit_reached
);

`include "masked_byte_pattern_search_assert.svh"

  logic [LEN_BITS-1:0]  pattern_length;
  logic [HIT_BITS-1:0]  hit_limit;
  logic [ADDR_BITS-1:0] range_start;
  logic [ADDR_BITS-1:0] range_end;

  logic [LEN_BITS-1:0]  fill;
  logic [ADDR_BITS-1:0] last_address;
  logic [HIT_BITS-1:0]  hit_count;
  logic                 dirty;
  logic                 rebuilding;
  logic [IDX_BITS-1:0]  sweep;
  logic                 pend_valid;
  logic [ADDR_BITS-1:0] pend_addr;

  logic [IDX_BITS-1:0]  lenm1;
  logic [HIT_BITS-1:0]  lim;
  logic [HIT_BITS-1:0]  hit_count_eff;
  logic [SUM_BITS-1:0]  sweep_sum;
  logic                 pend_hit, pend_go, pend_take;
  logic                 scan_block, accept, is_load, is_scan, is_start;
  logic                 in_range, gap, scan_live, scan_shift, scan_drop;
  logic                 restart, rebuild_start, sweep_last;
  cell_ctrl_t           ctrl;

  logic [MAX_PATTERN-1:0] hit_vec;
  logic [MAX_PATTERN-1:0] prev_hit;
  logic [MAX_PATTERN-1:0] load_we;
  logic [BYTE_BITS-1:0]   byte_q [MAX_PATTERN];

  always_comb begin
    if (pattern_length == '0) begin
      lenm1 = '0;
    end else if (pattern_length > LEN_BITS'(MAX_PATTERN)) begin
      lenm1 = IDX_BITS'(MAX_PATTERN - 1);
    end else begin
      lenm1 = IDX_BITS'(pattern_length - LEN_BITS'(1));
    end
  end

  assign lim = (hit_limit > HIT_BITS'(MAX_HITS)) ? HIT_BITS'(MAX_HITS) : hit_limit;

  // the pending byte's verdict is read from the row in the cycle after its shift
  assign pend_hit      = pend_valid && hit_vec[lenm1];
  assign pend_go       = pend_valid && (!pend_hit || !out_valid || out_ready);
  assign pend_take     = pend_go && pend_hit;
  assign hit_count_eff = hit_count + HIT_BITS'(pend_take);

  // scan beats wait while the row holds flags built from an older pattern
  assign scan_block = dirty && (fill != '0) && (req_type == REQ_SCAN);
  assign in_ready   = !rebuilding && (!pend_valid || pend_go) && !scan_block;
  assign accept     = in_valid && in_ready;
  assign is_load    = accept && (req_type == REQ_LOAD);
  assign is_scan    = accept && (req_type == REQ_SCAN);
  assign is_start   = accept && (req_type == REQ_START);

  assign in_range   = (byte_address >= range_start) && (byte_address < range_end);
  assign gap        = byte_address != (last_address + ADDR_BITS'(1));
  assign scan_live  = is_scan && (hit_count_eff < lim);
  assign scan_shift = scan_live && in_range;
  assign scan_drop  = scan_live && !in_range;

  assign rebuild_start = in_valid && scan_block && !rebuilding && !pend_valid;
  assign sweep_last    = sweep == IDX_BITS'(MAX_PATTERN - 1);
  assign sweep_sum     = SUM_BITS'(sweep) + SUM_BITS'(fill);

  // replay rotates the byte ring oldest first; slots beyond the run length are cleared
  always_comb begin
    ctrl.step     = rebuilding || scan_shift;
    ctrl.clr      = rebuilding && (sweep_sum < SUM_BITS'(MAX_PATTERN));
    ctrl.cmp_byte = rebuilding ? byte_q[MAX_PATTERN-1] : data_byte;
    ctrl.pat_data = pattern_value;
    ctrl.msk_data = mask_value;
    if (rebuilding) begin
      restart = sweep_sum == SUM_BITS'(MAX_PATTERN);
    end else begin
      restart = (fill == '0) || gap;
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_row
    if (k == 0) begin : g_head
      assign prev_hit[k] = 1'b1;
      mbps_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .load_we  (load_we[k]),
        .byte_in  (ctrl.cmp_byte),
        .prev_hit (prev_hit[k]),
        .byte_q   (byte_q[k]),
        .hit      (hit_vec[k])
      );
    end else begin : g_body
      assign prev_hit[k] = hit_vec[k-1] && !restart;
      mbps_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .load_we  (load_we[k]),
        .byte_in  (byte_q[k-1]),
        .prev_hit (prev_hit[k]),
        .byte_q   (byte_q[k]),
        .hit      (hit_vec[k])
      );
    end
    assign load_we[k] = is_load && (entry_index == IDX_BITS'(k));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_BITS'(1);
      hit_limit      <= HIT_BITS'(MAX_HITS);
      range_start    <= '0;
      range_end      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_BITS-1:0];
        REG_HIT_LIMIT:      hit_limit      <= cfg_data[HIT_BITS-1:0];
        REG_RANGE_START:    range_start    <= cfg_data[ADDR_BITS-1:0];
        REG_RANGE_END:      range_end      <= cfg_data[ADDR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      last_address <= '0;
      hit_count    <= '0;
      dirty        <= 1'b0;
      rebuilding   <= 1'b0;
      sweep        <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (is_start || scan_drop) begin
        fill <= '0;
      end else if (scan_shift) begin
        if (restart) begin
          fill <= LEN_BITS'(1);
        end else if (fill != LEN_BITS'(MAX_PATTERN)) begin
          fill <= fill + LEN_BITS'(1);
        end
        last_address <= byte_address;
      end

      if (is_start) begin
        hit_count <= '0;
      end else if (pend_take) begin
        hit_count <= hit_count + HIT_BITS'(1);
      end

      if (is_load) begin
        dirty <= 1'b1;
      end else if (is_scan || is_start || (rebuilding && sweep_last)) begin
        dirty <= 1'b0;
      end

      if (rebuild_start) begin
        rebuilding <= 1'b1;
        sweep      <= '0;
      end else if (rebuilding) begin
        sweep <= sweep + IDX_BITS'(1);
        if (sweep_last) begin
          rebuilding <= 1'b0;
        end
      end

      if (scan_shift) begin
        pend_valid <= 1'b1;
      end else if (pend_go) begin
        pend_valid <= 1'b0;
      end

      if (pend_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_shift) begin
      pend_addr <= byte_address - ADDR_BITS'(lenm1);
    end
    if (pend_take) begin
      match_address <= pend_addr;
      hits_so_far   <= hit_count + HIT_BITS'(1);
      limit_reached <= (hit_count + HIT_BITS'(1)) == lim;
    end
  end

  `MBPS_CHECK_NOW(a_replay_stalls, clk, rst, rebuilding, !in_ready && !pend_valid, "beat taken during replay")
  `MBPS_CHECK_NEXT(a_replay_ends, clk, rst, rebuilding && sweep_last, !rebuilding && !dirty, "replay did not finish")
  `MBPS_CHECK_NOW(a_hits_nonzero, clk, rst, out_valid, hits_so_far != '0, "result with zero hit count")
  `MBPS_CHECK_NOW(a_fill_bound, clk, rst, fill != '0, fill <= LEN_BITS'(MAX_PATTERN), "run length overflow")

endmodule

`default_nettype wire

FILE: sim/masked_byte_pattern_search_test.sv
module masked_byte_pattern_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbps_pkg::*;

  localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
  localparam logic [ADDR_BITS-1:0] TOP_ADDRESS = {ADDR_BITS{1'b1}};
  // a pattern load during an open run costs a replay inside the block
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [REQ_BITS-1:0]  kind;
    logic [IDX_BITS-1:0]  index;
    logic [BYTE_BITS-1:0] pattern;
    logic [BYTE_BITS-1:0] mask;
    logic [BYTE_BITS-1:0] data;
    logic [ADDR_BITS-1:0] addr;
  } search_req_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [HIT_BITS-1:0]  hits;
    logic                 limit;
  } match_hit_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [REQ_BITS-1:0]     req_type = '0;
  logic [IDX_BITS-1:0]     entry_index = '0;
  logic [BYTE_BITS-1:0]    pattern_value = '0;
  logic [BYTE_BITS-1:0]    mask_value = '0;
  logic [BYTE_BITS-1:0]    data_byte = '0;
  logic [ADDR_BITS-1:0]    byte_address = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [ADDR_BITS-1:0]    match_address;
  logic [HIT_BITS-1:0]     hits_so_far;
  logic                    limit_reached;

  masked_byte_pattern_search DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .entry_index(entry_index),
    .pattern_value(pattern_value),
    .mask_value(mask_value),
    .data_byte(data_byte),
    .byte_address(byte_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .match_address(match_address),
    .hits_so_far(hits_so_far),
    .limit_reached(limit_reached)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  search_req_t pending_requests[$];
  match_hit_t  expected_matches[$];

  // register copy, written only while the block is idle
  logic [LEN_BITS-1:0]  cfg_len = 9'd1;
  logic [HIT_BITS-1:0]  cfg_limit = 11'd1024;
  logic [ADDR_BITS-1:0] cfg_lo = '0;
  logic [ADDR_BITS-1:0] cfg_hi = '0;

  // search state as the block should hold it
  logic [BYTE_BITS-1:0] stored_pattern [MAX_PATTERN];
  logic [BYTE_BITS-1:0] stored_mask [MAX_PATTERN];
  logic [BYTE_BITS-1:0] window_bytes [MAX_PATTERN];
  int unsigned          run_fill = 0;
  logic [ADDR_BITS-1:0] last_addr = '0;
  int unsigned          hit_total = 0;

  // pattern as queued so far, used to build matching data
  logic [BYTE_BITS-1:0] plan_pattern [MAX_PATTERN];
  logic [BYTE_BITS-1:0] plan_mask [MAX_PATTERN];
  logic [ADDR_BITS-1:0] next_addr = '0;

  int          idle_pct = 20;
  int          send_gap = 0;
  int          hold_gap = 0;
  logic        in_taken = 1'b0;
  int unsigned fail_count = 0;
  int unsigned beats_taken = 0;
  int unsigned hits_checked = 0;
  int unsigned settings_used = 0;
  match_hit_t  head_match;

  initial begin
    for (int i = 0; i < MAX_PATTERN; i++) window_bytes[i] = '0;
  end

  function automatic int unsigned active_length();
    if (cfg_len == 0) return 1;
    if (cfg_len > MAX_PATTERN) return MAX_PATTERN;
    return cfg_len;
  endfunction

  function automatic int unsigned active_limit();
    if (cfg_limit > MAX_HITS) return MAX_HITS;
    return cfg_limit;
  endfunction

  function automatic void track_search(search_req_t req);
    int unsigned len, lim, k;
    bit          hit;
    match_hit_t  m;
    len = active_length();
    lim = active_limit();
    case (req.kind)
      REQ_LOAD: begin
        stored_pattern[req.index] = req.pattern;
        stored_mask[req.index] = req.mask;
      end
      REQ_START: begin
        run_fill = 0;
        hit_total = 0;
      end
      REQ_SCAN: begin
        if (hit_total < lim) begin
          if (req.addr < cfg_lo || req.addr >= cfg_hi) begin
            run_fill = 0;
          end else begin
            if (run_fill != 0 && req.addr != last_addr + 1) run_fill = 0;
            for (k = MAX_PATTERN - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
            window_bytes[0] = req.data;
            if (run_fill < MAX_PATTERN) run_fill++;
            last_addr = req.addr;
            if (run_fill >= len) begin
              hit = 1'b1;
              // oldest byte of the window lines up with pattern entry 0
              for (k = 0; k < len; k++) begin
                if (stored_mask[k] != 0 && (window_bytes[len-1-k] & stored_mask[k]) !=
                    (stored_pattern[k] & stored_mask[k])) hit = 1'b0;
              end
              if (hit) begin
                hit_total++;
                m.addr = req.addr - (len - 1);
                m.hits = hit_total;
                m.limit = (hit_total == lim);
                expected_matches.push_back(m);
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      track_search(pending_requests[0]);
      void'(pending_requests.pop_front());
      beats_taken++;
    end
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      hits_checked++;
      if (expected_matches.size() == 0) begin
        $error("unexpected match beat: match_address %h hits_so_far %0d",
               match_address, hits_so_far);
        fail_count++;
      end else begin
        head_match = expected_matches.pop_front();
        if (match_address !== head_match.addr) begin
          $error("match_address: expected %h, got %h", head_match.addr, match_address);
          fail_count++;
        end
        if (hits_so_far !== head_match.hits) begin
          $error("hits_so_far: expected %0d, got %0d", head_match.hits, hits_so_far);
          fail_count++;
        end
        if (limit_reached !== head_match.limit) begin
          $error("limit_reached: expected %b, got %b", head_match.limit, limit_reached);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_taken) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_requests.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 5);
      end else begin
        in_valid <= 1'b1;
        req_type <= pending_requests[0].kind;
        entry_index <= pending_requests[0].index;
        pattern_value <= pending_requests[0].pattern;
        mask_value <= pending_requests[0].mask;
        data_byte <= pending_requests[0].data;
        byte_address <= pending_requests[0].addr;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_gap <= 0;
    end else if (hold_gap != 0) begin
      out_ready <= 1'b0;
      hold_gap <= hold_gap - 1;
    end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      out_ready <= 1'b0;
      hold_gap <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [ADDR_BITS-1:0] random_address();
    return {$urandom, $urandom};
  endfunction

  function automatic void push_req(logic [REQ_BITS-1:0] kind, logic [IDX_BITS-1:0] index,
                                   logic [BYTE_BITS-1:0] pattern, logic [BYTE_BITS-1:0] mask,
                                   logic [BYTE_BITS-1:0] data, logic [ADDR_BITS-1:0] addr);
    search_req_t req;
    req.kind = kind;
    req.index = index;
    req.pattern = pattern;
    req.mask = mask;
    req.data = data;
    req.addr = addr;
    pending_requests.push_back(req);
  endfunction

  function automatic void push_load(int unsigned index, logic [BYTE_BITS-1:0] pattern,
                                    logic [BYTE_BITS-1:0] mask);
    plan_pattern[index] = pattern;
    plan_mask[index] = mask;
    push_req(REQ_LOAD, index, pattern, mask, $urandom_range(0, 255), random_address());
  endfunction

  function automatic void push_scan(logic [BYTE_BITS-1:0] data, logic [ADDR_BITS-1:0] addr);
    push_req(REQ_SCAN, $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255), data, addr);
  endfunction

  function automatic void push_misc(logic [REQ_BITS-1:0] kind);
    push_req(kind, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255), random_address());
  endfunction

  function automatic logic [BYTE_BITS-1:0] shaped_byte(int unsigned pos);
    logic [BYTE_BITS-1:0] noise;
    noise = $urandom_range(0, 255);
    return (plan_pattern[pos] & plan_mask[pos]) | (noise & ~plan_mask[pos]);
  endfunction

  function automatic logic [ADDR_BITS-1:0] pick_base(int unsigned run_len);
    logic [ADDR_BITS-1:0] span;
    span = cfg_hi - cfg_lo;
    if (cfg_hi <= cfg_lo) return cfg_lo - $urandom_range(0, 4);
    case ($urandom_range(0, 5))
      0: return cfg_lo;
      1: return cfg_hi - (run_len / 2 + 1);      // runs off the end of the range
      2: return cfg_lo - $urandom_range(1, 3);   // begins just below the range
      default: begin
        if (span > run_len) return cfg_lo + random_address() % (span - run_len);
        return cfg_lo;
      end
    endcase
  endfunction

  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || expected_matches.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PATTERN_LENGTH: cfg_len = value[LEN_BITS-1:0];
      REG_HIT_LIMIT:      cfg_limit = value[HIT_BITS-1:0];
      REG_RANGE_START:    cfg_lo = value[ADDR_BITS-1:0];
      default:            cfg_hi = value[ADDR_BITS-1:0];
    endcase
  endtask

  task automatic configure(int unsigned len, int unsigned lim, logic [ADDR_BITS-1:0] lo,
                           logic [ADDR_BITS-1:0] hi);
    drain();
    write_reg(REG_PATTERN_LENGTH, len);
    write_reg(REG_HIT_LIMIT, lim);
    write_reg(REG_RANGE_START, lo);
    write_reg(REG_RANGE_END, hi);
    settings_used++;
  endtask

  // fresh scan with a new pattern over every entry in use
  task automatic new_pattern(int unsigned len);
    int unsigned          pos;
    logic [BYTE_BITS-1:0] m;
    push_misc(REQ_START);
    for (pos = 0; pos < len; pos++) begin
      case ($urandom_range(0, 9))
        0, 1:       m = 8'h00;
        2, 3, 4, 5: m = 8'hff;
        default:    m = $urandom_range(0, 255);
      endcase
      push_load(pos, $urandom_range(0, 255), m);
    end
  endtask

  task automatic scan_phase(int unsigned budget);
    int unsigned          len, made, run_len, shift, spoil, i;
    logic [ADDR_BITS-1:0] base;
    len = active_length();
    made = 0;
    while (made < budget) begin
      case ($urandom_range(0, 15))
        0: push_misc(REQ_START);
        1: push_misc(REQ_UNUSED);
        2: push_load($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        3: push_scan($urandom_range(0, 255), random_address());
        default: begin
          if ($urandom_range(0, 3) == 0) push_misc(REQ_START);
          run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len)
                                                : len + $urandom_range(0, len + 3);
          // continuing the last run keeps it open across loads
          base = ($urandom_range(0, 2) == 0) ? next_addr : pick_base(run_len);
          shift = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, len - 1);
          spoil = ($urandom_range(0, 3) == 0) ? $urandom_range(0, run_len - 1) : run_len;
          for (i = 0; i < run_len; i++) begin
            if (i == spoil)
              push_scan(shaped_byte((i + shift) % len) ^ (8'h01 << $urandom_range(0, 7)),
                        base + i);
            else
              push_scan(shaped_byte((i + shift) % len), base + i);
          end
          next_addr = base + run_len;
          made += run_len;
        end
      endcase
      made++;
    end
  endtask

  initial begin
    int unsigned          len, lim;
    logic [ADDR_BITS-1:0] lo;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset range is empty, so this byte is dropped before the pattern is read
    push_scan(8'hff, '0);
    push_req(REQ_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, TOP_ADDRESS);
    push_load(0, 8'ha5, 8'hff);
    push_load(1, 8'h00, 8'h00);
    push_load(2, 8'hf0, 8'hf0);
    push_load(3, 8'h5a, 8'h0f);
    push_load(255, 8'hff, 8'hff);
    configure(4, 2, 48'h10, 48'h100);
    push_scan(8'ha5, 48'h0f);
    push_scan(8'ha5, 48'h10);
    push_scan(8'h37, 48'h11);
    push_scan(8'hf3, 48'h12);
    push_scan(8'hea, 48'h13);
    // address gap restarts the window, second hit reaches the limit
    push_scan(8'ha5, 48'h20);
    push_scan(8'h00, 48'h21);
    push_scan(8'hf0, 48'h22);
    push_scan(8'h0a, 48'h23);
    push_scan(8'ha5, 48'h24);
    push_misc(REQ_START);
    push_scan(8'ha5, 48'hfc);
    push_scan(8'h11, 48'hfd);
    push_scan(8'hff, 48'hfe);
    push_scan(8'h5a, 48'hff);
    push_scan(8'h00, 48'h100);
    push_scan(8'h00, TOP_ADDRESS);

    // zero length acts as one, limit of one
    configure(0, 1, '0, TOP_ADDRESS);
    new_pattern(1);
    scan_phase(120);

    // oversized length saturates to the full row, near the top of the address space
    configure(511, 3, TOP_ADDRESS - 48'hffff, TOP_ADDRESS);
    new_pattern(MAX_PATTERN);
    scan_phase(500);

    // zero hit limit: every scan byte is ignored
    idle_pct = 0;
    configure(2, 0, '0, TOP_ADDRESS);
    new_pattern(2);
    scan_phase(40);

    // inverted range never matches
    idle_pct = 30;
    configure(3, MAX_HITS, 48'h8000, 48'h7000);
    new_pattern(3);
    scan_phase(40);

    repeat (6) begin
      case ($urandom_range(0, 3))
        0:       len = $urandom_range(1, 4);
        1:       len = $urandom_range(5, 16);
        2:       len = $urandom_range(17, 40);
        default: len = 0;
      endcase
      case ($urandom_range(0, 3))
        0:       lim = $urandom_range(1, 3);
        1:       lim = $urandom_range(4, 64);
        2:       lim = MAX_HITS;
        default: lim = $urandom_range(MAX_HITS + 1, 2047);
      endcase
      lo = ($urandom_range(0, 2) == 0) ? '0 : random_address();
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      configure(len, lim, lo, lo + $urandom_range(64, 1 << 20));
      new_pattern(active_length());
      scan_phase(100);
    end

    // wildcard single byte: every byte hits until the saturated limit stops the scan
    idle_pct = 0;
    configure(1, 2047, '0, TOP_ADDRESS);
    push_misc(REQ_START);
    push_load(0, $urandom_range(0, 255), 8'h00);
    repeat (MAX_HITS + 6) push_scan($urandom_range(0, 255), random_address());

    drain();
    $display("covered %0d request beats under %0d register settings", beats_taken,
             settings_used);
    $display("checked %0d match beats across range edges, address gaps and hit limits",
             hits_checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: masked_byte_pattern_search.f
+incdir+src
src/mbps_pkg.sv
src/mbps_cell.sv
src/masked_byte_pattern_search.sv
sim/masked_byte_pattern_search_test.sv
